// ===== design/nhp_pkg.sv =====
// ============================================================================
// nhp_pkg: shared definitions for the name hash placer
// Constants, configuration register indexes and state encodings.
// ============================================================================
`default_nettype none

package nhp_pkg;

    // Largest table in buckets, as log2
    localparam int TABLE_MAX_LOG2_DEF = 10;

    // Hash datapath
    localparam int HASH_W     = 32;
    localparam int CHAR_W     = 8;
    localparam int FOLD_SHIFT = 4;

    // Result fields
    localparam int BUCKET_W = 10;
    localparam int COUNT_W  = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(1024);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TSL_W      = 4;

    localparam logic [HASH_W-1:0] STEP_SCALE_RST = HASH_W'(1);
    localparam logic [HASH_W-1:0] HASH_SEED_RST  = '0;
    localparam logic [TSL_W-1:0]  TSL_RST        = TSL_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SCALE      = 2'd0,
        CFG_HASH_SEED       = 2'd1,
        CFG_TABLE_SIZE_LOG2 = 2'd2
    } cfg_index_t;

    // Front end sequencer
    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_ADD  = 2'd1,
        F_PUSH = 2'd2
    } front_state_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        B_CLEAR = 2'd0,
        B_IDLE  = 2'd1,
        B_READ  = 2'd2,
        B_CHECK = 2'd3
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/nhp_ram.sv =====
// ============================================================================
// nhp_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module nhp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/nhp_front.sv =====
// ============================================================================
// nhp_front: character intake and hash
// Accepts characters and clear commands, updates the running hash and
// hands one job per completed name or clear to the job queue.
// ============================================================================
`default_nettype none

module nhp_front
    import nhp_pkg::*;
#(
    parameter int TABLE_MAX_LOG2 = TABLE_MAX_LOG2_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      command,
    input  wire logic [CHAR_W-1:0]         character,
    input  wire logic                      last_char,
    input  wire logic [HASH_W-1:0]         step_scale,
    input  wire logic [HASH_W-1:0]         hash_seed,
    input  wire logic [TABLE_MAX_LOG2-1:0] slot_mask,
    output logic                           push_valid,
    input  wire logic                      push_ready,
    output logic                           push_clear,
    output logic [TABLE_MAX_LOG2-1:0]      push_home
);

    front_state_t              state_reg, state_next;
    logic [HASH_W-1:0]         hash_reg, hash_next;
    logic [HASH_W-1:0]         product_reg, product_next;
    logic [CHAR_W-1:0]         char_reg, char_next;
    logic                      last_reg, last_next;
    logic                      clear_reg, clear_next;
    logic [TABLE_MAX_LOG2-1:0] home_reg, home_next;
    logic [HASH_W-1:0]         sum;
    logic [HASH_W-1:0]         folded;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            hash_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        clear_reg   <= clear_next;
        home_reg    <= home_next;
    end

    // Hash update and fold: sign-extended char added after the product
    assign sum    = product_reg + hash_seed + {{(HASH_W-CHAR_W){char_reg[CHAR_W-1]}}, char_reg};
    assign folded = sum ^ (sum >> FOLD_SHIFT);

    assign push_clear = clear_reg;
    assign push_home  = home_reg;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        product_next = product_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        clear_next   = clear_reg;
        home_next    = home_reg;
        in_ready     = 1'b0;
        push_valid   = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (command)
                    begin
                        hash_next  = '0;
                        clear_next = 1'b1;
                        home_next  = '0;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        product_next = hash_reg * step_scale;
                        char_next    = character;
                        last_next    = last_char;
                        state_next   = F_ADD;
                    end
                end
            end
            F_ADD:
            begin
                if (last_reg)
                begin
                    hash_next  = '0;
                    clear_next = 1'b0;
                    home_next  = folded[TABLE_MAX_LOG2-1:0] & slot_mask;
                    state_next = F_PUSH;
                end
                else
                begin
                    hash_next  = sum;
                    state_next = F_IDLE;
                end
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/nhp_queue.sv =====
// ============================================================================
// nhp_queue: two-entry job queue
// Decouples the hash front end from the probing back end.
// ============================================================================
`default_nettype none

module nhp_queue #(
    parameter int WIDTH = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/nhp_back.sv =====
// ============================================================================
// nhp_back: bitmap probing and result output
// Clears the occupancy bitmap, probes linearly from the home bucket with a
// read and a check per bucket, marks a free one taken and holds the result.
// ============================================================================
`default_nettype none

module nhp_back
    import nhp_pkg::*;
#(
    parameter int TABLE_MAX_LOG2 = TABLE_MAX_LOG2_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [TABLE_MAX_LOG2-1:0] slot_mask,
    input  wire logic                      job_valid,
    output logic                           job_pop,
    input  wire logic                      job_clear,
    input  wire logic [TABLE_MAX_LOG2-1:0] job_home,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [BUCKET_W-1:0]            bucket,
    output logic                           collided,
    output logic                           table_full,
    output logic [COUNT_W-1:0]             collision_count
);

    localparam int SLOTS = 1 << TABLE_MAX_LOG2;

    back_state_t               state_reg, state_next;
    logic [TABLE_MAX_LOG2-1:0] addr_reg, addr_next;
    logic [TABLE_MAX_LOG2-1:0] probe_reg, probe_next;
    logic                      hit_reg, hit_next;
    logic [COUNT_W-1:0]        ccount_reg, ccount_next;
    logic                      out_valid_reg, out_valid_next;
    logic [BUCKET_W-1:0]       bucket_reg, bucket_next;
    logic                      coll_out_reg, coll_out_next;
    logic                      full_reg, full_next;
    logic [COUNT_W-1:0]        count_out_reg, count_out_next;
    logic                      mem_we;
    logic [0:0]                mem_wdata;
    logic [0:0]                mem_rdata;
    logic                      coll_now;
    logic [COUNT_W-1:0]        ccount_inc;
    logic                      can_out;

    // Occupancy bitmap
    nhp_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            addr_reg      <= '0;
            probe_reg     <= '0;
            ccount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            probe_reg     <= probe_next;
            ccount_reg    <= ccount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        hit_reg       <= hit_next;
        bucket_reg    <= bucket_next;
        coll_out_reg  <= coll_out_next;
        full_reg      <= full_next;
        count_out_reg <= count_out_next;
    end

    // Home bucket occupancy is seen on the first probe only
    assign coll_now   = (probe_reg == '0) ? mem_rdata[0] : hit_reg;
    assign ccount_inc = (coll_now && (ccount_reg < COUNT_MAX)) ?
                        ccount_reg + COUNT_W'(1) : ccount_reg;
    assign can_out    = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign bucket          = bucket_reg;
    assign collided        = coll_out_reg;
    assign table_full      = full_reg;
    assign collision_count = count_out_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        hit_next       = hit_reg;
        ccount_next    = ccount_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bucket_next    = bucket_reg;
        coll_out_next  = coll_out_reg;
        full_next      = full_reg;
        count_out_next = count_out_reg;
        job_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = 1'b0;

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + TABLE_MAX_LOG2'(1);
                if (addr_reg == '1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    if (job_clear)
                    begin
                        ccount_next = '0;
                        addr_next   = '0;
                        state_next  = B_CLEAR;
                    end
                    else
                    begin
                        addr_next  = job_home;
                        probe_next = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                hit_next = coll_now;
                if (!mem_rdata[0] || (probe_reg == slot_mask))
                begin
                    // Free bucket found or every bucket tried
                    if (can_out)
                    begin
                        out_valid_next = 1'b1;
                        full_next      = mem_rdata[0];
                        bucket_next    = mem_rdata[0] ? '0 : BUCKET_W'(addr_reg);
                        coll_out_next  = coll_now;
                        count_out_next = ccount_inc;
                        ccount_next    = ccount_inc;
                        mem_we         = !mem_rdata[0];
                        mem_wdata      = 1'b1;
                        state_next     = B_IDLE;
                    end
                end
                else
                begin
                    addr_next  = (addr_reg + TABLE_MAX_LOG2'(1)) & slot_mask;
                    probe_next = probe_reg + TABLE_MAX_LOG2'(1);
                    state_next = B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/name_hash_linear_probe_placer.sv =====
// ============================================================================
// name_hash_linear_probe_placer: multiplicative name hash with linear probing
// Hashes a name one character per transfer and places it in an occupancy
// bitmap, reporting bucket, collision and running collision count.
// ============================================================================
//
// Channel   Signals                                   Direction
// -------   ---------------------------------------   ---------
// in        in_valid/in_ready, command, character,    sink
//           last_char
// out       out_valid/out_ready, bucket, collided,    source
//           table_full, collision_count
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  sink
//
// Front end: multiply, then add, for each character; a last character or
// clear then waits in the push state while the job queue is full.
// Back end: dispatch, then read and check states per bucket (registered
// read), up to 2^table_size_log2 buckets, saturated at 2^TABLE_MAX_LOG2.
// Reset and each clear start a pass over all 2^TABLE_MAX_LOG2 bitmap bits.
// A stalled result holds the back end; input runs on until the queue fills.
// ============================================================================
`default_nettype none

module name_hash_linear_probe_placer
    import nhp_pkg::*;
#(
    parameter int TABLE_MAX_LOG2 = TABLE_MAX_LOG2_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  command,
    input  wire logic [CHAR_W-1:0]     character,
    input  wire logic                  last_char,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [BUCKET_W-1:0]        bucket,
    output logic                       collided,
    output logic                       table_full,
    output logic [COUNT_W-1:0]         collision_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [HASH_W-1:0]         step_scale_reg;
    logic [HASH_W-1:0]         hash_seed_reg;
    logic [TSL_W-1:0]          table_size_log2_reg;
    logic [TABLE_MAX_LOG2-1:0] slot_mask;
    logic                      push_valid;
    logic                      push_ready;
    logic                      push_clear;
    logic [TABLE_MAX_LOG2-1:0] push_home;
    logic                      job_valid;
    logic                      job_pop;
    logic [TABLE_MAX_LOG2:0]   job_data;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg      <= STEP_SCALE_RST;
            hash_seed_reg       <= HASH_SEED_RST;
            table_size_log2_reg <= TSL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STEP_SCALE:      step_scale_reg      <= cfg_data;
                CFG_HASH_SEED:       hash_seed_reg       <= cfg_data;
                CFG_TABLE_SIZE_LOG2: table_size_log2_reg <= cfg_data[TSL_W-1:0];
                default:             ;
            endcase
        end
    end

    // Active bucket mask, size saturates at the table maximum
    assign slot_mask = (32'(table_size_log2_reg) > TABLE_MAX_LOG2) ? '1 :
                       ~({TABLE_MAX_LOG2{1'b1}} << table_size_log2_reg);

    nhp_front #(
        .TABLE_MAX_LOG2 (TABLE_MAX_LOG2)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .character  (character),
        .last_char  (last_char),
        .step_scale (step_scale_reg),
        .hash_seed  (hash_seed_reg),
        .slot_mask  (slot_mask),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_clear (push_clear),
        .push_home  (push_home)
    );

    nhp_queue #(
        .WIDTH (TABLE_MAX_LOG2 + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_clear, push_home}),
        .pop_valid  (job_valid),
        .pop        (job_pop),
        .pop_data   (job_data)
    );

    nhp_back #(
        .TABLE_MAX_LOG2 (TABLE_MAX_LOG2)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .slot_mask       (slot_mask),
        .job_valid       (job_valid),
        .job_pop         (job_pop),
        .job_clear       (job_data[TABLE_MAX_LOG2]),
        .job_home        (job_data[TABLE_MAX_LOG2-1:0]),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bucket          (bucket),
        .collided        (collided),
        .table_full      (table_full),
        .collision_count (collision_count)
    );

endmodule

`default_nettype wire

// ===== design/nhp_checker.sv =====
// ============================================================================
// nhp_checker: port-level checks for the name hash placer
// Watches the result channel and the consistency of result fields.
// ============================================================================
`default_nettype none

module nhp_checker
    import nhp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [BUCKET_W-1:0]   bucket,
    input wire logic                  collided,
    input wire logic                  table_full,
    input wire logic [COUNT_W-1:0]    collision_count
);

    // A stalled result stays up with its payload unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bucket) &&
        $stable(collided) && $stable(table_full) && $stable(collision_count))
        else $error("result changed while stalled");

    // A full table reports bucket 0 and counts as a collision
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> collided && (bucket == '0))
        else $error("full table result malformed");

    // The counter saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> collision_count <= COUNT_MAX)
        else $error("collision count above limit");

    // A collision is always reflected in the count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collided |-> collision_count != '0)
        else $error("collision not counted");

endmodule

bind name_hash_linear_probe_placer nhp_checker u_nhp_checker (.*);

`default_nettype wire
